// ===== hdl/mats_pkg.sv =====
package mats_pkg;

  localparam int unsigned MssW     = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned WordW    = 32;
  localparam int unsigned MetricW  = 64;
  localparam int unsigned NumW     = WordW + 1;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [MssW-1:0] MssReset = 16'd1200;

  // s_axis_tdata: path_number, congestion_window, bytes_in_flight,
  //               smoothed_rtt, backlog, packet_origin_path
  localparam int unsigned InDataW  = 160;
  // s_axis_tuser: reinjecting, is_retransmission
  localparam int unsigned InUserW  = 2;
  // m_axis_tdata: chosen_path, chosen_metric
  localparam int unsigned OutDataW = 80;
  // m_axis_tuser: path_found
  localparam int unsigned OutUserW = 1;

  localparam int unsigned UserReinj = 0;
  localparam int unsigned UserRetx  = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic div_step;
    logic mul;
    logic sum;
    logic update;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_wait;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/mats_ctrl.sv =====
module mats_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mats_pkg::dp_status_t status_i,
  output mats_pkg::ctrl_cmd_t  cmd_o
);
  import mats_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        // no queueing delay: skip the divider, quotient stays zero
        state_d    = status_i.zero_wait ? ST_MUL : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.last ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/mats_dp.sv =====
module mats_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [mats_pkg::MssW-1:0]         cfg_wr_data_i,
  input  logic [mats_pkg::InDataW-1:0]      in_data_i,
  input  logic [mats_pkg::InUserW-1:0]      in_user_i,
  input  logic                              in_last_i,
  input  mats_pkg::ctrl_cmd_t               cmd_i,
  output mats_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mats_pkg::OutDataW-1:0]     out_data_o,
  output logic [mats_pkg::OutUserW-1:0]     out_user_o
);
  import mats_pkg::*;

  logic [MssW-1:0]    mss_q;

  // captured record
  logic [IdW-1:0]     pid_q, origin_q;
  logic [WordW-1:0]   cwnd_q, infl_q, srtt_q, queued_q;
  logic               reinj_q, retx_q, last_q;

  // divider
  logic [NumW-1:0]    num_q, quot_q;
  logic [WordW-1:0]   rem_q, dvs_q;
  logic               has_space_q;

  logic [MetricW-1:0] prod_q, metric_q;

  // scan state
  logic               best_valid_q, backup_valid_q;
  logic [IdW-1:0]     best_id_q, backup_id_q;
  logic [MetricW-1:0] best_cost_q, backup_cost_q;

  logic               out_valid_q;
  logic               out_found_q;
  logic [IdW-1:0]     out_id_q;
  logic [MetricW-1:0] out_metric_q;

  logic [WordW-1:0]   avail;
  logic               zero_wait, has_space;
  logic [NumW-1:0]    num_d;
  logic [WordW-1:0]   mss_ext, dvs_d;
  logic [NumW-1:0]    trial, trial_diff;
  logic               trial_ge;
  logic [MetricW-1:0] prod_d, add_term;
  logic               is_backup, take_best, take_backup, out_free;

  assign avail     = cwnd_q - infl_q;
  // inflight above cwnd wraps avail to a huge value, so the wait is zero too
  assign zero_wait = (infl_q > cwnd_q) || (queued_q < avail);
  assign has_space = (infl_q < cwnd_q) && (queued_q <= avail);
  assign num_d     = {1'b0, queued_q} - {1'b0, avail} + NumW'(mss_q);
  assign mss_ext   = WordW'(mss_q);

  always_comb begin
    dvs_d = (cwnd_q < mss_ext) ? mss_ext : cwnd_q;
    if (dvs_d == '0) begin
      dvs_d = WordW'(1);
    end
  end

  assign trial      = {rem_q, num_q[NumW-1]};
  assign trial_ge   = trial >= {1'b0, dvs_q};
  assign trial_diff = trial - {1'b0, dvs_q};

  assign prod_d   = quot_q[WordW-1:0] * srtt_q;
  // top quotient bit times srtt lands above bit 31, srtt/2 below it
  assign add_term = {(quot_q[NumW-1] ? srtt_q : {WordW{1'b0}}), 1'b0, srtt_q[WordW-1:1]};

  assign is_backup   = reinj_q && (origin_q == pid_q);
  assign take_backup = is_backup && has_space_q &&
                       (!backup_valid_q || (metric_q < backup_cost_q));
  assign take_best   = !is_backup && (!retx_q || has_space_q) &&
                       (!best_valid_q || (metric_q < best_cost_q));

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_q <= MssReset;
    end else if (cfg_wr_en_i) begin
      mss_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pid_q    <= in_data_i[15:0];
      cwnd_q   <= in_data_i[47:16];
      infl_q   <= in_data_i[79:48];
      srtt_q   <= in_data_i[111:80];
      queued_q <= in_data_i[143:112];
      origin_q <= in_data_i[159:144];
      reinj_q  <= in_user_i[UserReinj];
      retx_q   <= in_user_i[UserRetx];
      last_q   <= in_last_i;
    end
    if (cmd_i.prep) begin
      num_q       <= num_d;
      rem_q       <= '0;
      dvs_q       <= dvs_d;
      quot_q      <= '0;
      has_space_q <= has_space;
    end else if (cmd_i.div_step) begin
      num_q  <= {num_q[NumW-2:0], 1'b0};
      quot_q <= {quot_q[NumW-2:0], trial_ge};
      rem_q  <= trial_ge ? trial_diff[WordW-1:0] : trial[WordW-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.sum) begin
      metric_q <= prod_q + add_term;
    end
    if (cmd_i.emit) begin
      if (best_valid_q) begin
        out_found_q  <= 1'b1;
        out_id_q     <= best_id_q;
        out_metric_q <= best_cost_q;
      end else if (backup_valid_q) begin
        out_found_q  <= 1'b1;
        out_id_q     <= backup_id_q;
        out_metric_q <= backup_cost_q;
      end else begin
        out_found_q  <= 1'b0;
        out_id_q     <= '0;
        out_metric_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q   <= 1'b0;
      best_id_q      <= '0;
      best_cost_q    <= '1;
      backup_valid_q <= 1'b0;
      backup_id_q    <= '0;
      backup_cost_q  <= '1;
    end else if (cmd_i.emit) begin
      best_valid_q   <= 1'b0;
      best_id_q      <= '0;
      best_cost_q    <= '1;
      backup_valid_q <= 1'b0;
      backup_id_q    <= '0;
      backup_cost_q  <= '1;
    end else if (cmd_i.update) begin
      if (take_best) begin
        best_valid_q <= 1'b1;
        best_id_q    <= pid_q;
        best_cost_q  <= metric_q;
      end
      if (take_backup) begin
        backup_valid_q <= 1'b1;
        backup_id_q    <= pid_q;
        backup_cost_q  <= metric_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.zero_wait = zero_wait;
  assign status_o.last      = last_q;
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_metric_q, out_id_q};
  assign out_user_o  = out_found_q;

endmodule

// ===== hdl/multipath_arrival_time_path_select.sv =====
// Arrival-time path selector, one path record at a time.
// Per record: a prep step, a 33-step radix-2 divider when the path has queued
// data to wait behind (skipped when not), one 32x32 multiply, a sum and an update;
// the last record of a scan adds an output step. One record in work at a time.
// Output: tvalid rises after the output step of the last record, later while the
// previous result is still held in the output register.
// Reset: async, active low; MSS back to 1200, scan state and output valid cleared.
module multipath_arrival_time_path_select (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_wr_en_i,
  input  logic [mats_pkg::MssW-1:0]          cfg_wr_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // path_number, congestion_window, bytes_in_flight, smoothed_rtt,
  // backlog, packet_origin_path
  input  logic [mats_pkg::InDataW-1:0]       s_axis_tdata,
  // reinjecting, is_retransmission
  input  logic [mats_pkg::InUserW-1:0]       s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // chosen_path, chosen_metric
  output logic [mats_pkg::OutDataW-1:0]      m_axis_tdata,
  // path_found
  output logic [mats_pkg::OutUserW-1:0]      m_axis_tuser
);
  import mats_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mats_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .in_last_i     (s_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_user_o    (m_axis_tuser)
  );

endmodule

// ===== hdl/mats_checker.sv =====
module mats_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [mats_pkg::OutDataW-1:0]      m_axis_tdata,
  input logic [mats_pkg::OutUserW-1:0]      m_axis_tuser
);
  import mats_pkg::*;

  // one record in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous record in work");

  // no path found means an all-zero result
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("nonzero result without a path");

  // a new result is only produced at the end of a record's processing
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input side was idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind multipath_arrival_time_path_select mats_checker u_mats_checker (.*);
